[design/wrns_pkg.sv]
package wrns_pkg;

  // Field widths
  localparam int COORD_W    = 16;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int IDX_OUT_W  = 6;
  localparam int FRAC_W     = 6;

  // Table depth default and cap on reported matches per query
  localparam int MAX_POINTS_DEF = 64;
  localparam int MATCH_CNT_W    = 7;
  localparam int MAX_MATCHES    = 64;

  // Register reset value in whole tiles
  localparam logic [CFG_W-1:0] MAP_SIZE_RST = 10'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  // Item kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

[design/wrns_ram.sv]
module wrns_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/wrapped_radius_neighbor_search.sv]
// Wrapped fixed-radius neighbour search over a table of stored points.
// Input channel (in_valid / in_stall): in_kind selects a store (append the
// point in_pos_x/y/z) or a query (report stored points within
// in_search_radius of the position, with wrap-around near the map edges).
// Result channel (out_valid / out_stall): a store gives one word carrying
// out_status (full table); a query gives one word per match in index order
// with out_found set, or a single word with out_found clear, out_last
// marking the final word of the item. map_width / map_height are written
// through cfg_we / cfg_index / cfg_wdata; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// Latency and throughput: a store result is valid the cycle after accept,
// and a store may be taken every cycle while results drain. A query scans
// one stored point per cycle through the point memory's single read port
// unless the scan pipeline is frozen; its final word is loaded once the
// read, difference and square stages have drained.
// Reset (rst_n low, synchronous) empties the table and sets both map sizes
// to 64 tiles; the point memory itself is not cleared. A stalled receiver
// holds the result word and freezes the scan pipeline while a further
// match waits for the output register; input is stalled during a query.
module wrapped_radius_neighbor_search #(
  parameter int MAX_POINTS = wrns_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [wrns_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wrns_pkg::CFG_W-1:0]            cfg_wdata,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic [wrns_pkg::COORD_W-1:0]          in_pos_x,
  input  logic [wrns_pkg::COORD_W-1:0]          in_pos_y,
  input  logic signed [wrns_pkg::COORD_W-1:0]   in_pos_z,
  input  logic [wrns_pkg::COORD_W-1:0]          in_search_radius,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [wrns_pkg::IDX_OUT_W-1:0]        out_neighbor_index,
  output logic                                  out_found,
  output logic                                  out_last,
  output logic                                  out_status
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW    = wrns_pkg::COORD_W;
  localparam int RAM_W = 3 * CW;
  localparam int DW    = CW + 1;   // axis difference, signed
  localparam int WW    = CW + 2;   // wrap arithmetic, signed
  localparam int SQ_W  = 2 * CW;   // square of one axis difference
  localparam int SUM_W = SQ_W + 2;

  typedef struct packed {
    logic                 hi;
    logic                 lo;
    logic signed [WW-1:0] t;
    logic signed [WW-1:0] rt;
  } wrap_t;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  // Per-axis edge flags for one query
  function automatic wrap_t wrap_setup(input logic [CW-1:0] q, input logic [CW-1:0] size,
                                       input logic [CW-1:0] r);
    wrap_t                s;
    logic signed [WW-1:0] q18;
    logic signed [WW-1:0] s18;
    logic signed [WW-1:0] r18;
    logic signed [WW-1:0] d;
    q18  = $signed({2'b00, q});
    s18  = $signed({2'b00, size});
    r18  = $signed({2'b00, r});
    d    = s18 - q18;
    s.hi = d < r18;
    s.lo = !s.hi && (q18 < r18);
    s.t  = s.hi ? d : (s.lo ? q18 : '0);
    s.rt = r18 - s.t;
    return s;
  endfunction

  // Wrapped difference of one stored coordinate; magnitude stays below 2^16
  function automatic logic signed [DW-1:0] wrap_diff(input logic [CW-1:0] q,
                                                     input logic [CW-1:0] p,
                                                     input logic [CW-1:0] size,
                                                     input wrap_t s);
    logic signed [WW-1:0] q18;
    logic signed [WW-1:0] p18;
    logic signed [WW-1:0] s18;
    logic signed [WW-1:0] d;
    q18 = $signed({2'b00, q});
    p18 = $signed({2'b00, p});
    s18 = $signed({2'b00, size});
    if (s.hi && (p18 < s.rt)) begin
      d = s.t + p18;
    end else if (s.lo && ((s18 - p18) < s.rt)) begin
      d = s.t + s18 - p18;
    end else begin
      d = q18 - p18;
    end
    return d[DW-1:0];
  endfunction

  // Control registers
  state_t                              state_r, state_nxt;
  logic [wrns_pkg::CFG_W-1:0]          map_width_r, map_height_r;
  logic [CNT_W-1:0]                    point_count_r, point_count_nxt;
  logic [CNT_W-1:0]                    idx_r, idx_nxt;
  logic [wrns_pkg::MATCH_CNT_W-1:0]    n_r, n_nxt;
  logic                                v1_r, v2_r, v3_r;
  logic                                pend_valid_r, pend_valid_nxt;
  logic                                out_valid_r, out_valid_nxt;

  // Payload registers
  logic [CW-1:0]                       q_x_r, q_y_r, q_z_r;
  logic [CW-1:0]                       h_r, w_r;
  logic [SQ_W-1:0]                     r2_r;
  wrap_t                               wx_r, wy_r;
  logic [IDX_W-1:0]                    idx1_r, idx2_r, idx3_r;
  logic signed [DW-1:0]                dx2_r, dy2_r, dz2_r;
  logic [SQ_W-1:0]                     sx3_r, sy3_r, sz3_r;
  logic [IDX_W-1:0]                    pend_idx_r, pend_idx_nxt;
  logic [wrns_pkg::IDX_OUT_W-1:0]      out_idx_r, out_idx_nxt;
  logic                                out_found_r, out_found_nxt;
  logic                                out_last_r, out_last_nxt;
  logic                                out_status_r, out_status_nxt;

  logic                                out_free, in_acc, store_acc, query_acc, table_full;
  logic                                issue, adv, match3, scan_done, out_load;
  logic [CW-1:0]                       h_in, w_in;
  logic [RAM_W-1:0]                    rdata;
  logic [CW-1:0]                       p_x, p_y, p_z;
  logic signed [2*DW-1:0]              sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]                    d2;
  logic [IDX_W+wrns_pkg::IDX_OUT_W-1:0] pend_idx_ext, idx3_ext;

  // Handshake
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != ST_IDLE) || ((in_kind == wrns_pkg::KIND_STORE) && !out_free);
  assign in_acc     = in_valid && !in_stall;
  assign store_acc  = in_acc && (in_kind == wrns_pkg::KIND_STORE);
  assign query_acc  = in_acc && (in_kind == wrns_pkg::KIND_QUERY);
  assign table_full = point_count_r == CNT_W'(MAX_POINTS);

  // Map extents in Q10.6
  assign h_in = {map_height_r, {wrns_pkg::FRAC_W{1'b0}}};
  assign w_in = {map_width_r, {wrns_pkg::FRAC_W{1'b0}}};

  // Point memory: x, y, z packed in one word
  wrns_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (store_acc && !table_full),
    .waddr (point_count_r[IDX_W-1:0]),
    .wdata ({in_pos_x, in_pos_y, in_pos_z}),
    .re    (issue && adv),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign p_x = rdata[3*CW-1:2*CW];
  assign p_y = rdata[2*CW-1:CW];
  assign p_z = rdata[CW-1:0];

  // Scan control: freeze the pipeline while a second match meets a full output
  assign issue     = (state_r == ST_SCAN) && (idx_r < point_count_r);
  assign sq_x      = dx2_r * dx2_r;
  assign sq_y      = dy2_r * dy2_r;
  assign sq_z      = dz2_r * dz2_r;
  assign d2        = {2'b00, sx3_r} + {2'b00, sy3_r} + {2'b00, sz3_r};
  assign match3    = v3_r && (d2 <= {2'b00, r2_r}) && (d2 != '0) &&
                     (n_r < wrns_pkg::MATCH_CNT_W'(wrns_pkg::MAX_MATCHES));
  assign adv       = !(match3 && pend_valid_r && !out_free);
  assign scan_done = (state_r == ST_SCAN) && !issue && !v1_r && !v2_r && !v3_r;

  assign pend_idx_ext = {{wrns_pkg::IDX_OUT_W{1'b0}}, pend_idx_r};
  assign idx3_ext     = {{wrns_pkg::IDX_OUT_W{1'b0}}, idx3_r};

  // Next state of control and result word
  always_comb begin
    state_nxt       = state_r;
    point_count_nxt = point_count_r;
    idx_nxt         = idx_r;
    n_nxt           = n_r;
    pend_valid_nxt  = pend_valid_r;
    pend_idx_nxt    = pend_idx_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_idx_nxt     = out_idx_r;
    out_found_nxt   = out_found_r;
    out_last_nxt    = out_last_r;
    out_status_nxt  = out_status_r;
    out_load        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (store_acc) begin
          out_load       = 1'b1;
          out_idx_nxt    = '0;
          out_found_nxt  = 1'b0;
          out_last_nxt   = 1'b1;
          out_status_nxt = table_full ? wrns_pkg::STATUS_FULL : wrns_pkg::STATUS_OK;
          if (!table_full) begin
            point_count_nxt = point_count_r + 1'b1;
          end
        end else if (query_acc) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
          n_nxt     = '0;
        end
      end
      ST_SCAN: begin
        if (issue && adv) begin
          idx_nxt = idx_r + 1'b1;
        end
        // Hold one match back so the final one can carry last
        if (match3 && adv) begin
          n_nxt          = n_r + 1'b1;
          pend_valid_nxt = 1'b1;
          pend_idx_nxt   = idx3_r;
          if (pend_valid_r) begin
            out_load       = 1'b1;
            out_idx_nxt    = pend_idx_ext[wrns_pkg::IDX_OUT_W-1:0];
            out_found_nxt  = 1'b1;
            out_last_nxt   = 1'b0;
            out_status_nxt = wrns_pkg::STATUS_OK;
          end
        end
        // Close the item once the pipeline has drained
        if (scan_done && out_free) begin
          out_load       = 1'b1;
          out_idx_nxt    = pend_valid_r ? pend_idx_ext[wrns_pkg::IDX_OUT_W-1:0] : '0;
          out_found_nxt  = pend_valid_r;
          out_last_nxt   = 1'b1;
          out_status_nxt = wrns_pkg::STATUS_OK;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // State, counters, valid bits, result word and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      map_width_r   <= wrns_pkg::MAP_SIZE_RST;
      map_height_r  <= wrns_pkg::MAP_SIZE_RST;
      point_count_r <= '0;
      idx_r         <= '0;
      n_r           <= '0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      out_idx_r     <= '0;
      out_found_r   <= 1'b0;
      out_last_r    <= 1'b0;
      out_status_r  <= wrns_pkg::STATUS_OK;
    end else begin
      state_r       <= state_nxt;
      point_count_r <= point_count_nxt;
      idx_r         <= idx_nxt;
      n_r           <= n_nxt;
      pend_valid_r  <= pend_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      out_idx_r     <= out_idx_nxt;
      out_found_r   <= out_found_nxt;
      out_last_r    <= out_last_nxt;
      out_status_r  <= out_status_nxt;
      if (adv) begin
        v1_r <= issue;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          wrns_pkg::REG_MAP_WIDTH:  map_width_r  <= cfg_wdata;
          wrns_pkg::REG_MAP_HEIGHT: map_height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Query set-up and scan pipeline
  always_ff @(posedge clk) begin
    if (query_acc) begin
      q_x_r <= in_pos_x;
      q_y_r <= in_pos_y;
      q_z_r <= in_pos_z;
      h_r   <= h_in;
      w_r   <= w_in;
      r2_r  <= in_search_radius * in_search_radius;
      wx_r  <= wrap_setup(in_pos_x, h_in, in_search_radius);
      wy_r  <= wrap_setup(in_pos_y, w_in, in_search_radius);
    end
    if (adv) begin
      idx1_r <= idx_r[IDX_W-1:0];
      idx2_r <= idx1_r;
      idx3_r <= idx2_r;
      dx2_r  <= wrap_diff(q_x_r, p_x, h_r, wx_r);
      dy2_r  <= wrap_diff(q_y_r, p_y, w_r, wy_r);
      dz2_r  <= $signed({q_z_r[CW-1], q_z_r}) - $signed({p_z[CW-1], p_z});
      sx3_r  <= sq_x[SQ_W-1:0];
      sy3_r  <= sq_y[SQ_W-1:0];
      sz3_r  <= sq_z[SQ_W-1:0];
    end
    pend_idx_r <= pend_idx_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_neighbor_index = out_idx_r;
  assign out_found          = out_found_r;
  assign out_last           = out_last_r;
  assign out_status         = out_status_r;

  // The table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    point_count_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table depth");

  // A held-back match exists only during a scan
  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == ST_SCAN))
    else $error("pending match outside a scan");

  // An accepted store with room grows the table by one
  a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (store_acc && !table_full) |=> (point_count_r == $past(point_count_r) + 1'b1))
    else $error("store did not append");

  // Pipeline is empty whenever a new query starts
  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |-> (!v1_r && !v2_r && !v3_r))
    else $error("query started over a busy pipeline");

  // A frozen pipeline always has a match waiting behind a full output
  a_freeze_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> (pend_valid_r && out_valid_r && out_stall))
    else $error("pipeline frozen without cause");

endmodule

[test/tb_wrapped_radius_neighbor_search.sv]
module tb_wrapped_radius_neighbor_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = wrns_pkg::MAX_POINTS_DEF + 8;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 48;
  localparam int CW            = wrns_pkg::COORD_W;
  localparam int PTS           = wrns_pkg::MAX_POINTS_DEF;

  // Indexes past the register list, which the block must ignore
  localparam logic [wrns_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [wrns_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [CW-1:0] COORD_MAX = '1;
  localparam logic [CW-1:0] Z_MOST_NEG = 16'h8000;
  localparam logic [CW-1:0] Z_MOST_POS = 16'h7FFF;

  typedef struct packed {
    logic          kind;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [CW-1:0] radius;
  } probe_t;

  typedef struct packed {
    logic [wrns_pkg::IDX_OUT_W-1:0] slot;
    logic                           found;
    logic                           last;
    logic                           status;
  } hit_t;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [wrns_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [wrns_pkg::CFG_W-1:0]       cfg_wdata;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_kind;
  logic [CW-1:0]                    in_pos_x;
  logic [CW-1:0]                    in_pos_y;
  logic signed [CW-1:0]             in_pos_z;
  logic [CW-1:0]                    in_search_radius;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [wrns_pkg::IDX_OUT_W-1:0]   out_neighbor_index;
  logic                             out_found;
  logic                             out_last;
  logic                             out_status;

  // Local copy of the point table and map size registers
  logic [CW-1:0]              pt_x [PTS];
  logic [CW-1:0]              pt_y [PTS];
  logic [CW-1:0]              pt_z [PTS];
  int                         pt_count;
  logic [wrns_pkg::CFG_W-1:0] map_w_tiles;
  logic [wrns_pkg::CFG_W-1:0] map_h_tiles;

  hit_t due_results[$];

  int  fault_count;
  int  n_stores;
  int  n_refused;
  int  n_queries;
  int  n_neighbours;
  int  cycle_count;
  int  burst_left;
  bit  gaps_on;
  bit  stall_on;
  int  stall_run;
  bit  stall_level;

  wrapped_radius_neighbor_search #(
    .MAX_POINTS(PTS)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_search_radius   (in_search_radius),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_neighbor_index (out_neighbor_index),
    .out_found          (out_found),
    .out_last           (out_last),
    .out_status         (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               due_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stall pattern: alternating runs of stall and pass
  always @(negedge clk) begin
    if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_level = ~stall_level;
        stall_run = stall_level ? $urandom_range(1, 6) : $urandom_range(1, 10);
      end
      stall_run--;
      out_stall <= stall_level;
    end
  end

  // Queue one word the block owes, oldest first
  function automatic void add_due(input hit_t h);
    due_results.insert(due_results.size(), h);
  endfunction

  // Signed distance along one axis, folded across the map edge when near it
  function automatic longint axis_gap(input longint q, input longint p,
                                      input longint span, input longint r);
    longint t;
    bit     near_top;
    bit     near_base;
    t = 0;
    near_top = 1'b0;
    near_base = 1'b0;
    if (span - q < r) begin
      near_top = 1'b1;
      t = span - q;
    end else if (q < r) begin
      near_base = 1'b1;
      t = q;
    end
    if (near_top && p < r - t) return t + p;
    if (near_base && span - p < r - t) return t + span - p;
    return q - p;
  endfunction

  // Append a point or scan the table, queueing the words the block owes
  function automatic void compute_neighbours(input probe_t p);
    longint span_x;
    longint span_y;
    longint r;
    longint dx;
    longint dy;
    longint dz;
    longint d2;
    int     n;
    hit_t   h;
    h = '0;
    if (p.kind == wrns_pkg::KIND_STORE) begin
      n_stores++;
      h.last = 1'b1;
      if (pt_count < PTS) begin
        pt_x[pt_count] = p.x;
        pt_y[pt_count] = p.y;
        pt_z[pt_count] = p.z;
        pt_count++;
        h.status = wrns_pkg::STATUS_OK;
      end else begin
        h.status = wrns_pkg::STATUS_FULL;
        n_refused++;
      end
      add_due(h);
    end else begin
      n_queries++;
      span_x = longint'(map_h_tiles) * 64;
      span_y = longint'(map_w_tiles) * 64;
      r = longint'(p.radius);
      n = 0;
      for (int i = 0; i < pt_count; i++) begin
        dx = axis_gap(longint'(p.x), longint'(pt_x[i]), span_x, r);
        dy = axis_gap(longint'(p.y), longint'(pt_y[i]), span_y, r);
        dz = longint'($signed(p.z)) - longint'($signed(pt_z[i]));
        d2 = dx * dx + dy * dy + dz * dz;
        if (d2 <= r * r && d2 != 0 && n < wrns_pkg::MAX_MATCHES) begin
          h = '0;
          h.slot = i[wrns_pkg::IDX_OUT_W-1:0];
          h.found = 1'b1;
          h.status = wrns_pkg::STATUS_OK;
          add_due(h);
          n++;
        end
      end
      n_neighbours += n;
      if (n == 0) begin
        h = '0;
        h.last = 1'b1;
        h.status = wrns_pkg::STATUS_OK;
        add_due(h);
      end else begin
        due_results[due_results.size() - 1].last = 1'b1;
      end
    end
  endfunction

  function automatic void log_fault(input string what, input hit_t want, input hit_t seen);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%s at cycle %0d: expected idx %0d found %0b last %0b status %0b,",
               what, cycle_count, want.slot, want.found, want.last, want.status,
               " got idx %0d found %0b last %0b status %0b",
               seen.slot, seen.found, seen.last, seen.status);
  endfunction

  // Check every accepted result word against the oldest one due
  always @(posedge clk) begin : watch_results
    hit_t seen;
    hit_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen.slot = out_neighbor_index;
      seen.found = out_found;
      seen.last = out_last;
      seen.status = out_status;
      if (due_results.size() == 0) begin
        log_fault("unexpected word", '0, seen);
      end else begin
        want = due_results.pop_front();
        if (seen.slot !== want.slot || seen.found !== want.found ||
            seen.last !== want.last || seen.status !== want.status)
          log_fault("mismatch", want, seen);
      end
    end
  end

  // Offer one word, hold it until taken, then maybe leave a gap
  task automatic send_item(input probe_t p);
    in_valid <= 1'b1;
    in_kind <= p.kind;
    in_pos_x <= p.x;
    in_pos_y <= p.y;
    in_pos_z <= p.z;
    in_search_radius <= p.radius;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_neighbours(p);
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid and hold off until every due word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(input logic [wrns_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wrns_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      wrns_pkg::REG_MAP_WIDTH:  map_w_tiles = val;
      wrns_pkg::REG_MAP_HEIGHT: map_h_tiles = val;
      default: ;
    endcase
  endtask

  task automatic set_map(input logic [wrns_pkg::CFG_W-1:0] w,
                         input logic [wrns_pkg::CFG_W-1:0] h);
    wait_drained();
    reg_write(wrns_pkg::REG_MAP_WIDTH, w);
    reg_write(wrns_pkg::REG_MAP_HEIGHT, h);
  endtask

  task automatic store_pt(input logic [CW-1:0] x, input logic [CW-1:0] y,
                          input logic [CW-1:0] z);
    probe_t p;
    p.kind = wrns_pkg::KIND_STORE;
    p.x = x;
    p.y = y;
    p.z = z;
    p.radius = 16'($urandom);
    send_item(p);
  endtask

  task automatic query_pt(input logic [CW-1:0] x, input logic [CW-1:0] y,
                          input logic [CW-1:0] z, input logic [CW-1:0] r);
    probe_t p;
    p.kind = wrns_pkg::KIND_QUERY;
    p.x = x;
    p.y = y;
    p.z = z;
    p.radius = r;
    send_item(p);
  endtask

  function automatic logic [CW-1:0] nudge(input logic [CW-1:0] v, input int spread);
    int t;
    t = int'(v) + int'($urandom_range(0, 2 * spread)) - spread;
    return t[CW-1:0];
  endfunction

  // Coordinates cluster near both map edges so the wrap paths get exercised
  function automatic logic [CW-1:0] pick_coord(input longint span);
    longint v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 127);
      1: v = span - 128 + $urandom_range(0, 192);
      2: v = (span > 0) ? $urandom_range(0, int'(span) - 1) : 0;
      default: v = $urandom_range(0, 65535);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] pick_radius();
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2, 3: return 16'($urandom_range(1, 511));
      4, 5:    return 16'($urandom_range(512, 4095));
      6:       return 16'($urandom_range(4096, 20000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly stores and queries clustered around points already held
  function automatic probe_t random_probe();
    probe_t p;
    int     j;
    longint span_x;
    longint span_y;
    p = '0;
    span_x = longint'(map_h_tiles) * 64;
    span_y = longint'(map_w_tiles) * 64;
    p.radius = 16'($urandom);
    p.kind = (pt_count == 0 || $urandom_range(0, 9) < 4) ? wrns_pkg::KIND_STORE
                                                         : wrns_pkg::KIND_QUERY;
    if (pt_count > 0 && $urandom_range(0, 4) != 0) begin
      j = $urandom_range(0, pt_count - 1);
      p.x = nudge(pt_x[j], 300);
      p.y = nudge(pt_y[j], 300);
      p.z = nudge(pt_z[j], 300);
    end else begin
      p.x = pick_coord(span_x);
      p.y = pick_coord(span_y);
      p.z = $urandom_range(0, 1) ? nudge('0, 1024) : 16'($urandom);
    end
    if (p.kind == wrns_pkg::KIND_QUERY) p.radius = pick_radius();
    return p;
  endfunction

  // Empty table query, then stores at the coordinate extremes
  task automatic test_basic_stores();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    query_pt('0, '0, '0, 16'd100);
    store_pt('0, '0, '0);
    store_pt(COORD_MAX, COORD_MAX, Z_MOST_NEG);
    store_pt(16'd64, 16'd64, Z_MOST_POS);
    store_pt(16'd4000, 16'd100, '0);
    store_pt(16'd100, 16'd4090, '0);
    store_pt(16'd130, 16'd130, 16'd10);
  endtask

  // Zero radius, query on a stored point (not its own match), wrap on both edges, full radius
  task automatic test_directed_queries();
    query_pt('0, '0, '0, '0);
    query_pt('0, '0, '0, 16'd200);
    query_pt(16'd4090, 16'd4090, '0, 16'd300);
    query_pt(16'd64, 16'd64, Z_MOST_POS, 16'd1);
    query_pt(COORD_MAX, COORD_MAX, Z_MOST_NEG, COORD_MAX);
    query_pt(16'h8000, 16'h8000, 16'hFFFF, 16'hAAAA);
    query_pt(16'h5555, 16'hAAAA, 16'h5555, 16'h5555);
    wait_drained();
  endtask

  // Map size extremes, zero size and writes to unused indexes
  task automatic test_register_writes();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    set_map(10'd1023, 10'd1023);
    query_pt(16'd65500, 16'd65500, '0, 16'd2000);
    set_map(10'd1, 10'd1);
    query_pt(16'd10, 16'd60, '0, 16'd100);
    query_pt('0, '0, '0, COORD_MAX);
    set_map(10'd0, 10'd0);
    query_pt('0, '0, '0, 16'd300);
    query_pt(16'd130, 16'd130, '0, 16'd300);
    wait_drained();
    reg_write(REG_SPARE_LO, '1);
    reg_write(REG_SPARE_HI, '0);
    query_pt(16'd120, 16'd120, '0, 16'd300);
    wait_drained();
  endtask

  // Random traffic over several map settings, idling varied per phase
  task automatic test_random_traffic(input int total);
    int                         per_phase;
    logic [wrns_pkg::CFG_W-1:0] w;
    logic [wrns_pkg::CFG_W-1:0] h;
    per_phase = total / 6;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin w = 10'd64;   h = 10'd64;   end
        1:       begin w = 10'd1023; h = 10'd1023; end
        2:       begin w = 10'd1;    h = 10'd1023; end
        3:       begin w = 10'd0;    h = 10'd0;    end
        4:       begin w = 10'd1023; h = 10'd1;    end
        default: begin
          w = 10'($urandom_range(1, 1023));
          h = 10'($urandom_range(1, 1023));
        end
      endcase
      set_map(w, h);
      gaps_on = (ph != 2);
      stall_on = (ph != 2) && (ph != 4);
      for (int k = 0; k < per_phase; k++) send_item(random_probe());
    end
    wait_drained();
  endtask

  // Fill the table, push it past full, then scan the full table
  task automatic test_full_table();
    probe_t p;
    set_map(10'd64, 10'd64);
    gaps_on = 1'b1;
    stall_on = 1'b1;
    while (pt_count < PTS) begin
      p = random_probe();
      p.kind = wrns_pkg::KIND_STORE;
      send_item(p);
    end
    for (int k = 0; k < 3; k++) store_pt(16'($urandom), 16'($urandom), 16'($urandom));
    for (int k = 0; k < 6; k++) begin
      p = random_probe();
      p.kind = wrns_pkg::KIND_QUERY;
      p.radius = pick_radius();
      send_item(p);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = wrns_pkg::KIND_STORE;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_search_radius = '0;
    pt_count = 0;
    map_w_tiles = wrns_pkg::MAP_SIZE_RST;
    map_h_tiles = wrns_pkg::MAP_SIZE_RST;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_stores();
    test_directed_queries();
    test_register_writes();
    test_random_traffic(RANDOM_ITEMS);
    test_full_table();

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("ran %0d stores (%0d refused, table full) and %0d queries finding %0d neighbours",
             n_stores, n_refused, n_queries, n_neighbours);
    $display("map sizes 0 to 1023 tiles, unused register indexes, bursty input, stalled output");
    if (fault_count == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d faults, %0d words never arrived", fault_count, due_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
